// ----- src/ptrs_pkg.sv -----
// ============================================================================
// ptrs_pkg
// Shared types, constants and helpers for the periodic task release scheduler.
// ============================================================================
package ptrs_pkg;

  // Fixed field widths
  localparam int TIME_W          = 32;
  localparam int PERIOD_W        = 16;
  localparam int NUM_PERIOD_REGS = 7;
  localparam int MASK_W          = 7;
  localparam int SIDX_W          = 3;
  localparam int CFG_ADDR_W      = 5;
  localparam int CFG_DATA_W      = 32;
  localparam int OUT_DATA_W      = 16;

  // Input operation codes carried on tuser
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Register index of the service count; period i lives at index i + 1
  localparam logic [2:0] REG_SERVICE_COUNT = 3'd0;

  typedef logic [PERIOD_W-1:0] period_t;
  typedef period_t [NUM_PERIOD_REGS-1:0] period_arr_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_READ,
    ST_CHECK,
    ST_DIVIDE,
    ST_WRITE,
    ST_DONE
  } ptrs_state_t;

  // Remainder of a small start index by the service count (count 0 gives a).
  function automatic logic [SIDX_W-1:0] start_mod(input logic [SIDX_W-1:0] a,
                                                  input logic [SIDX_W-1:0] m);
    logic [SIDX_W-1:0] r;
    r = a;
    for (int i = 0; i < 7; i++) begin
      if (m != '0 && r >= m) begin
        r = r - m;
      end
    end
    return r;
  endfunction

endpackage

// ----- src/periodic_task_release_scheduler.sv -----
// ============================================================================
// periodic_task_release_scheduler
// Releases periodic services on timer ticks and tracks their next releases.
// ============================================================================
// Usage:
//   The input stream carries one command per transfer: tuser selects a timer
//   tick (0) or a start (1), tdata holds the current time in ms. Every input
//   transfer yields exactly one output transfer with the release mask and
//   the index where the next scan begins. The user must set the periods and the
//   service count over the APB port while the block is idle, unchecked by the block.
// Processing:
//   A start writes every next-release entry, one per cycle, before its result
//   is formed. A tick reads and checks each service in turn from the scan start
//   and updates each due one, stopping at the first service not yet due; a due
//   service late by a full period or more first passes through the remainder
//   unit, which retires one bit of the lag per cycle. The block takes no new
//   command until the current one is done; the input is ready again in the same
//   cycle that the result enters the output register.
// Reset:
//   Synchronous reset clears all next-release times to zero, the scan start
//   to zero, the count to zero and every period to 1.
// Stall:
//   The result sits in an output register; while the receiver stalls, the
//   block still accepts and processes the next command, then holds its result.
// ============================================================================
module periodic_task_release_scheduler #(
  parameter int MAX_SERVICES = 7
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] now_ms
  input  logic        s_tuser,   // [0] operation
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [6:0] release_mask, [9:7] start_index, [15:10] zero
);

  localparam int IDX_W = (MAX_SERVICES > 1) ? $clog2(MAX_SERVICES) : 1;

  logic [ptrs_pkg::SIDX_W-1:0]   service_count;
  ptrs_pkg::period_arr_t         periods;
  logic                          mem_we;
  logic [IDX_W-1:0]              mem_waddr;
  logic [ptrs_pkg::TIME_W-1:0]   mem_wdata;
  logic                          mem_re;
  logic [IDX_W-1:0]              mem_raddr;
  logic [ptrs_pkg::TIME_W-1:0]   mem_rdata;
  logic                          rem_start;
  logic [ptrs_pkg::TIME_W-1:0]   rem_dividend;
  logic [ptrs_pkg::PERIOD_W-1:0] rem_divisor;
  logic                          rem_done;
  logic [ptrs_pkg::PERIOD_W-1:0] rem_value;

  // Configuration registers.
  ptrs_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .service_count (service_count),
    .periods       (periods)
  );

  // Next-release store.
  ptrs_mem #(
    .MAX_SERVICES (MAX_SERVICES)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Lag remainder unit.
  ptrs_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (rem_dividend),
    .divisor  (rem_divisor),
    .done     (rem_done),
    .value    (rem_value)
  );

  // Scan sequencer and output register.
  ptrs_seq #(
    .MAX_SERVICES (MAX_SERVICES)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .service_count (service_count),
    .periods       (periods),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .rem_start     (rem_start),
    .rem_dividend  (rem_dividend),
    .rem_divisor   (rem_divisor),
    .rem_done      (rem_done),
    .rem_value     (rem_value)
  );

endmodule

// ----- src/ptrs_regs.sv -----
// ============================================================================
// ptrs_regs
// Configuration register file behind the APB-style port.
// ============================================================================
module ptrs_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ptrs_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [ptrs_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [ptrs_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready,
  output logic [ptrs_pkg::SIDX_W-1:0]          service_count,
  output ptrs_pkg::period_arr_t                periods
);

  logic       wr_en;
  logic [2:0] reg_idx;
  logic [2:0] per_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign per_idx = reg_idx - 3'd1;

  // Register writes complete in the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      service_count <= '0;
      for (int i = 0; i < ptrs_pkg::NUM_PERIOD_REGS; i++) begin
        periods[i] <= ptrs_pkg::PERIOD_W'(1);
      end
    end else if (wr_en) begin
      if (reg_idx == ptrs_pkg::REG_SERVICE_COUNT) begin
        service_count <= pwdata[ptrs_pkg::SIDX_W-1:0];
      end else begin
        periods[per_idx] <= pwdata[ptrs_pkg::PERIOD_W-1:0];
      end
    end
  end

  // Read data returns the addressed register.
  always_comb begin
    if (reg_idx == ptrs_pkg::REG_SERVICE_COUNT) begin
      prdata = ptrs_pkg::CFG_DATA_W'(service_count);
    end else begin
      prdata = ptrs_pkg::CFG_DATA_W'(periods[per_idx]);
    end
  end

endmodule

// ----- src/ptrs_mem.sv -----
// ============================================================================
// ptrs_mem
// Next-release time store: one write and one registered read port per cycle.
// ============================================================================
module ptrs_mem #(
  parameter int MAX_SERVICES = 7
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       we,
  input  logic [((MAX_SERVICES > 1) ? $clog2(MAX_SERVICES) : 1)-1:0] waddr,
  input  logic [ptrs_pkg::TIME_W-1:0]                wdata,
  input  logic                                       re,
  input  logic [((MAX_SERVICES > 1) ? $clog2(MAX_SERVICES) : 1)-1:0] raddr,
  output logic [ptrs_pkg::TIME_W-1:0]                rdata
);

  logic [ptrs_pkg::TIME_W-1:0] mem [MAX_SERVICES];
  logic [MAX_SERVICES-1:0]     valid;
  logic [ptrs_pkg::TIME_W-1:0] rd_data;
  logic                        rd_valid;

  // Storage array; entries never written read back as zero.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

  // Per-entry valid bits, cleared at once by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (re) begin
        rd_valid <= valid[raddr];
      end
    end
  end

  assign rdata = rd_valid ? rd_data : '0;

endmodule

// ----- src/ptrs_rem.sv -----
// ============================================================================
// ptrs_rem
// Bit-serial remainder unit: 32-bit dividend modulo 16-bit divisor.
// ============================================================================
module ptrs_rem (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [ptrs_pkg::TIME_W-1:0]      dividend,
  input  logic [ptrs_pkg::PERIOD_W-1:0]    divisor,
  output logic                             done,
  output logic [ptrs_pkg::PERIOD_W-1:0]    value
);

  localparam int CNT_W = $clog2(ptrs_pkg::TIME_W);

  logic                            busy;
  logic [CNT_W-1:0]                cnt;
  logic [ptrs_pkg::TIME_W-1:0]     dvd;
  logic [ptrs_pkg::PERIOD_W-1:0]   dsr;
  logic [ptrs_pkg::PERIOD_W-1:0]   r;
  logic [ptrs_pkg::PERIOD_W:0]     trial;
  logic                            ge;
  logic [ptrs_pkg::PERIOD_W-1:0]   r_step;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    trial  = {r, dvd[ptrs_pkg::TIME_W-1]};
    ge     = trial >= {1'b0, dsr};
    r_step = ge ? ptrs_pkg::PERIOD_W'(trial - {1'b0, dsr})
                : trial[ptrs_pkg::PERIOD_W-1:0];
  end

  // Control: busy for one step per dividend bit, then a done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(ptrs_pkg::TIME_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      r   <= '0;
      cnt <= '0;
    end else if (busy) begin
      dvd <= {dvd[ptrs_pkg::TIME_W-2:0], 1'b0};
      r   <= r_step;
      cnt <= cnt + CNT_W'(1);
    end
  end

  assign value = r;

endmodule

// ----- src/ptrs_seq.sv -----
// ============================================================================
// ptrs_seq
// Scan sequencer: read-modify-write of next-release times and result output.
// ============================================================================
module ptrs_seq #(
  parameter int MAX_SERVICES = 7
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [ptrs_pkg::TIME_W-1:0]           s_tdata,
  input  logic                                  s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [ptrs_pkg::OUT_DATA_W-1:0]       m_tdata,
  input  logic [ptrs_pkg::SIDX_W-1:0]           service_count,
  input  ptrs_pkg::period_arr_t                 periods,
  output logic                                  mem_we,
  output logic [((MAX_SERVICES > 1) ? $clog2(MAX_SERVICES) : 1)-1:0] mem_waddr,
  output logic [ptrs_pkg::TIME_W-1:0]           mem_wdata,
  output logic                                  mem_re,
  output logic [((MAX_SERVICES > 1) ? $clog2(MAX_SERVICES) : 1)-1:0] mem_raddr,
  input  logic [ptrs_pkg::TIME_W-1:0]           mem_rdata,
  output logic                                  rem_start,
  output logic [ptrs_pkg::TIME_W-1:0]           rem_dividend,
  output logic [ptrs_pkg::PERIOD_W-1:0]         rem_divisor,
  input  logic                                  rem_done,
  input  logic [ptrs_pkg::PERIOD_W-1:0]         rem_value
);

  localparam int IDX_W = (MAX_SERVICES > 1) ? $clog2(MAX_SERVICES) : 1;
  localparam int CNT_W = $clog2(MAX_SERVICES + 1);

  ptrs_pkg::ptrs_state_t state, state_next;

  logic [ptrs_pkg::TIME_W-1:0]     now_ms;
  logic [IDX_W-1:0]                idx;
  logic [CNT_W-1:0]                visited;
  logic [CNT_W-1:0]                count;
  logic [ptrs_pkg::MASK_W-1:0]     mask;
  logic [ptrs_pkg::SIDX_W-1:0]     scan_start;
  logic [ptrs_pkg::PERIOD_W-1:0]   rem_r;
  logic                            out_valid;
  logic [ptrs_pkg::OUT_DATA_W-1:0] out_data;

  logic [CNT_W-1:0]                count_in;
  logic [CNT_W-1:0]                idx_inc;
  logic [CNT_W-1:0]                visited_inc;
  logic [ptrs_pkg::PERIOD_W-1:0]   per_raw;
  logic [ptrs_pkg::PERIOD_W-1:0]   eff_per;
  logic [ptrs_pkg::TIME_W-1:0]     diff;
  logic                            due;
  logic                            short_gap;
  logic [ptrs_pkg::TIME_W:0]       sum;
  logic [ptrs_pkg::TIME_W-1:0]     next_val;
  logic                            out_free;

  // Datapath helpers: effective period, due test and the advanced release time.
  always_comb begin
    count_in    = (service_count > ptrs_pkg::SIDX_W'(MAX_SERVICES))
                  ? CNT_W'(MAX_SERVICES) : CNT_W'(service_count);
    idx_inc     = CNT_W'(idx) + CNT_W'(1);
    visited_inc = visited + CNT_W'(1);
    per_raw     = periods[ptrs_pkg::SIDX_W'(idx)];
    eff_per     = (per_raw == '0) ? ptrs_pkg::PERIOD_W'(1) : per_raw;
    diff        = now_ms - mem_rdata;
    due         = now_ms >= mem_rdata;
    short_gap   = (diff[ptrs_pkg::TIME_W-1:ptrs_pkg::PERIOD_W] == '0) &&
                  (diff[ptrs_pkg::PERIOD_W-1:0] < eff_per);
    // Next release = now - ((now - next) mod period) + period, saturated.
    sum         = {1'b0, now_ms} - (ptrs_pkg::TIME_W + 1)'(rem_r)
                  + (ptrs_pkg::TIME_W + 1)'(eff_per);
    next_val    = sum[ptrs_pkg::TIME_W] ? '1 : sum[ptrs_pkg::TIME_W-1:0];
    out_free    = !out_valid || m_tready;
  end

  // Next state and handshake / memory controls.
  always_comb begin
    state_next   = state;
    s_tready     = (state == ptrs_pkg::ST_IDLE);
    mem_we       = (state == ptrs_pkg::ST_SWEEP) || (state == ptrs_pkg::ST_WRITE);
    mem_waddr    = idx;
    mem_wdata    = (state == ptrs_pkg::ST_SWEEP) ? now_ms : next_val;
    mem_re       = (state == ptrs_pkg::ST_READ);
    mem_raddr    = idx;
    rem_start    = (state == ptrs_pkg::ST_CHECK) && due && !short_gap;
    rem_dividend = diff;
    rem_divisor  = eff_per;
    unique case (state)
      ptrs_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == ptrs_pkg::OP_START) begin
            state_next = ptrs_pkg::ST_SWEEP;
          end else if (count_in == '0) begin
            state_next = ptrs_pkg::ST_DONE;
          end else begin
            state_next = ptrs_pkg::ST_READ;
          end
        end
      end
      ptrs_pkg::ST_SWEEP: begin
        if (idx == IDX_W'(MAX_SERVICES - 1)) begin
          state_next = ptrs_pkg::ST_DONE;
        end
      end
      ptrs_pkg::ST_READ: begin
        state_next = ptrs_pkg::ST_CHECK;
      end
      ptrs_pkg::ST_CHECK: begin
        priority if (!due) begin
          state_next = ptrs_pkg::ST_DONE;
        end else if (short_gap) begin
          state_next = ptrs_pkg::ST_WRITE;
        end else begin
          state_next = ptrs_pkg::ST_DIVIDE;
        end
      end
      ptrs_pkg::ST_DIVIDE: begin
        if (rem_done) begin
          state_next = ptrs_pkg::ST_WRITE;
        end
      end
      ptrs_pkg::ST_WRITE: begin
        if (visited_inc == count) begin
          state_next = ptrs_pkg::ST_DONE;
        end else begin
          state_next = ptrs_pkg::ST_READ;
        end
      end
      ptrs_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = ptrs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ptrs_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state: FSM, stored scan start and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ptrs_pkg::ST_IDLE;
      scan_start <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ptrs_pkg::ST_CHECK && !due) begin
        scan_start <= ptrs_pkg::SIDX_W'(idx);
      end
      if (state == ptrs_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    unique case (state)
      ptrs_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          now_ms  <= s_tdata;
          mask    <= '0;
          visited <= '0;
          count   <= count_in;
          if (s_tuser == ptrs_pkg::OP_START) begin
            idx <= '0;
          end else begin
            idx <= IDX_W'(ptrs_pkg::start_mod(scan_start, ptrs_pkg::SIDX_W'(count_in)));
          end
        end
      end
      ptrs_pkg::ST_SWEEP: begin
        idx <= idx + IDX_W'(1);
      end
      ptrs_pkg::ST_CHECK: begin
        if (due) begin
          mask <= mask | (ptrs_pkg::MASK_W'(1) << idx);
          if (short_gap) begin
            rem_r <= diff[ptrs_pkg::PERIOD_W-1:0];
          end
        end
      end
      ptrs_pkg::ST_DIVIDE: begin
        if (rem_done) begin
          rem_r <= rem_value;
        end
      end
      ptrs_pkg::ST_WRITE: begin
        visited <= visited_inc;
        idx     <= (idx_inc == count) ? '0 : IDX_W'(idx_inc);
      end
      ptrs_pkg::ST_DONE: begin
        if (out_free) begin
          out_data <= {6'b0, scan_start, mask};
        end
      end
      default: begin
      end
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

`ifndef SYNTHESIS
  a_rem_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    rem_done |-> state == ptrs_pkg::ST_DIVIDE)
    else $error("remainder result arrived outside the divide state");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ptrs_pkg::ST_WRITE) |-> (CNT_W'(idx) < count))
    else $error("release update addressed a service not in use");

  a_scan_start_range: assert property (@(posedge clk) disable iff (rst)
    scan_start < ptrs_pkg::SIDX_W'(MAX_SERVICES))
    else $error("stored scan start beyond the service range");

  a_check_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == ptrs_pkg::ST_CHECK) |-> $past(state) == ptrs_pkg::ST_READ)
    else $error("due check without a preceding memory read");
`endif

endmodule

// ----- tb/release_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// release_checker
// Watches the register port and both streams of the release scheduler,
// predicts each result and compares it field by field.
// ============================================================================
module release_checker (
  input  logic        clk,
  input  logic        rst,
  // Register port, observed only
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  // Command stream
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] now_ms
  input  logic        s_tuser,   // [0] operation
  // Result stream
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [6:0] release_mask, [9:7] start_index
  // Status for the test top
  output int          mismatches,
  output int          pending,
  output int          released
);

  localparam int MAX_SVC          = 7;
  localparam int PERIOD_REG_FIRST = int'(ptrs_pkg::REG_SERVICE_COUNT) + 1;

  typedef struct packed {
    logic [ptrs_pkg::SIDX_W-1:0] start_index;
    logic [ptrs_pkg::MASK_W-1:0] mask;
  } release_t;

  // Shadow copy of the scheduler's registers and state
  logic [2:0]        svc_count;
  ptrs_pkg::period_t period_q [ptrs_pkg::NUM_PERIOD_REGS];
  logic [31:0]       due_at   [MAX_SVC];
  logic [2:0]        scan_idx;

  release_t    expected_releases [$];

  // Next release after catching up past now, saturating at the top of time.
  function automatic logic [31:0] next_due(input logic [31:0] due, input logic [31:0] now,
                                           input ptrs_pkg::period_t per);
    logic [63:0] per_eff;
    logic [63:0] steps;
    logic [63:0] cand;
    per_eff = (per == '0) ? 64'd1 : {48'd0, per};
    steps   = {32'd0, now - due} / per_eff + 64'd1;
    cand    = {32'd0, due} + steps * per_eff;
    return (cand > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : cand[31:0];
  endfunction

  // Applies one command to the shadow state and returns the result it causes.
  task automatic scan_services(input logic op, input logic [31:0] now,
                               output release_t res);
    int  cnt;
    int  base;
    int  idx;
    bit  stopped;
    res     = '0;
    stopped = 1'b0;
    if (op == ptrs_pkg::OP_START) begin
      for (int i = 0; i < MAX_SVC; i++) due_at[i] = now;
    end else begin
      cnt = int'(svc_count);
      if (cnt > MAX_SVC) cnt = MAX_SVC;
      if (cnt > 0) begin
        // A start index left over from a larger count wraps into range.
        base = int'(scan_idx) % cnt;
        for (int i = 0; i < cnt; i++) begin
          if (!stopped) begin
            idx = (base + i) % cnt;
            if (now >= due_at[idx]) begin
              res.mask[idx] = 1'b1;
              due_at[idx]   = next_due(due_at[idx], now, period_q[idx]);
              released++;
            end else begin
              scan_idx = idx[2:0];
              stopped  = 1'b1;
            end
          end
        end
      end
    end
    res.start_index = scan_idx;
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    end
  endtask

  // All channels are sampled at the rising edge, before the block updates.
  always @(posedge clk) begin : watch
    release_t want;
    release_t got;
    logic [2:0] reg_sel;
    if (rst) begin
      svc_count = '0;
      scan_idx  = '0;
      for (int i = 0; i < ptrs_pkg::NUM_PERIOD_REGS; i++) period_q[i] = 16'd1;
      for (int i = 0; i < MAX_SVC; i++) due_at[i] = '0;
      expected_releases.delete();
    end else begin
      // Register writes
      if (psel && penable && pwrite && pready) begin
        reg_sel = paddr[4:2];
        if (reg_sel == ptrs_pkg::REG_SERVICE_COUNT) begin
          svc_count = pwdata[2:0];
        end else begin
          period_q[int'(reg_sel) - PERIOD_REG_FIRST] = pwdata[15:0];
        end
      end
      // Result transfers are matched against the oldest expectation
      if (m_tvalid && m_tready) begin
        got = m_tdata[ptrs_pkg::MASK_W+ptrs_pkg::SIDX_W-1:0];
        if (expected_releases.size() == 0) begin
          flag_mismatch("result with nothing expected", 32'd0, {16'd0, m_tdata});
        end else begin
          want = expected_releases.pop_front();
          if (got.mask !== want.mask) begin
            flag_mismatch("release_mask", 32'(want.mask), 32'(got.mask));
          end
          if (got.start_index !== want.start_index) begin
            flag_mismatch("start_index", 32'(want.start_index), 32'(got.start_index));
          end
        end
      end
      // Command transfers feed the prediction
      if (s_tvalid && s_tready) begin
        scan_services(s_tuser, s_tdata, want);
        expected_releases.insert(expected_releases.size(), want);
      end
    end
    pending = expected_releases.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb
// Stimulus for the periodic task release scheduler.
// Directed commands cover the special cases first; then random register
// settings with start/tick sequences of rising time, mixed with noise, run
// under random gaps and back-pressure. The checker does all comparing.
// ============================================================================
module tb;

  localparam int PERIOD_REG_FIRST = int'(ptrs_pkg::REG_SERVICE_COUNT) + 1;
  localparam int ITEM_TARGET      = 1600;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] now_ms
  logic        s_tuser;   // [0] operation
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [6:0] release_mask, [9:7] start_index, [15:10] zero

  int          mismatches;
  int          pending;
  int          released;
  int          ticks_sent;
  int          starts_sent;
  int          settings_made;
  bit          quiet;       // no gaps and no stalls while set
  logic [31:0] clock_ms;    // time of the current well-formed sequence

  periodic_task_release_scheduler u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  release_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .pending    (pending),
    .released   (released)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // One command transfer; called and returning at a falling edge.
  task automatic send_cmd(input logic op, input logic [31:0] now);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= now;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (op == ptrs_pkg::OP_START) starts_sent++;
    else ticks_sent++;
  endtask

  // Stops sending and waits until every expected result has arrived.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Register write with a setup phase and an access phase, then an idle gap.
  task automatic reg_write(input int idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx[2:0], 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Writes the service count and every period once the block is idle.
  task automatic load_services(input logic [2:0] cnt, input ptrs_pkg::period_arr_t per);
    drain();
    reg_write(int'(ptrs_pkg::REG_SERVICE_COUNT), {29'd0, cnt});
    for (int i = 0; i < ptrs_pkg::NUM_PERIOD_REGS; i++) begin
      reg_write(PERIOD_REG_FIRST + i, {16'd0, per[i]});
    end
    settings_made++;
  endtask

  // Random setting, then a start and a run of ticks with rising time,
  // mixed with restarts, stray times and big jumps.
  task automatic random_phase(input int n_items, input bit hold_midway);
    ptrs_pkg::period_arr_t per;
    ptrs_pkg::period_t     tmp;
    logic [2:0]            cnt;
    logic [31:0]           dt;
    int                    r;
    quiet = ($urandom_range(0, 3) == 0);
    r     = $urandom_range(0, 9);
    cnt   = (r == 0) ? 3'd0 : (r < 4) ? 3'd7 : 3'($urandom_range(1, 7));
    // Mostly short periods so that scans rotate often
    for (int i = 0; i < ptrs_pkg::NUM_PERIOD_REGS; i++) begin
      r = $urandom_range(0, 15);
      if (r == 0)       per[i] = 16'd0;
      else if (r <= 10) per[i] = 16'($urandom_range(1, 12));
      else if (r <= 13) per[i] = 16'($urandom_range(13, 400));
      else if (r == 14) per[i] = 16'($urandom_range(401, 65534));
      else              per[i] = 16'hFFFF;
    end
    // Periods are loaded in ascending order
    for (int i = 1; i < ptrs_pkg::NUM_PERIOD_REGS; i++) begin
      for (int j = i; j > 0; j--) begin
        if (per[j-1] > per[j]) begin
          tmp      = per[j];
          per[j]   = per[j-1];
          per[j-1] = tmp;
        end
      end
    end
    load_services(cnt, per);

    r = $urandom_range(0, 9);
    if (r == 0)      clock_ms = $urandom;
    else if (r == 1) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 70000);
    else             clock_ms = $urandom_range(0, 1000000);
    send_cmd(ptrs_pkg::OP_START, clock_ms);

    for (int n = 1; n < n_items; n++) begin
      if (hold_midway && n == n_items / 2) drain();
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_cmd(ptrs_pkg::OP_START, clock_ms);
      end else if (r < 8) begin
        send_cmd(ptrs_pkg::OP_TICK, $urandom);
      end else if (r < 12) begin
        send_cmd(ptrs_pkg::OP_TICK, clock_ms - $urandom_range(1, 50));
      end else begin
        dt = (r < 20) ? $urandom_range(0, 150000) : $urandom_range(0, 3);
        // Time saturates rather than wrapping
        if (clock_ms > 32'hFFFF_FFFF - dt) clock_ms = 32'hFFFF_FFFF;
        else clock_ms = clock_ms + dt;
        send_cmd(ptrs_pkg::OP_TICK, clock_ms);
      end
    end
  endtask

  // Result side: a random stall before each transfer.
  initial begin : sink
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // Run limit, far beyond the slowest correct run
  initial begin
    #16_000_000;
    $display("FAIL periodic_task_release_scheduler");
    $finish;
  end

  initial begin : stimulus
    ptrs_pkg::period_arr_t per;
    bit                    first;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = ptrs_pkg::OP_TICK;
    quiet         = 1'b0;
    clock_ms      = '0;
    ticks_sent    = 0;
    starts_sent   = 0;
    settings_made = 0;
    rst           = 1'b1;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // No services in use after reset: a tick does nothing
    send_cmd(ptrs_pkg::OP_TICK, 32'd0);

    // Three services, the first with a zero period that acts as one
    per = {ptrs_pkg::NUM_PERIOD_REGS{16'd1}};
    per[0] = 16'd0;
    per[1] = 16'd2;
    per[2] = 16'd5;
    load_services(3'd3, per);
    send_cmd(ptrs_pkg::OP_START, 32'd100);
    send_cmd(ptrs_pkg::OP_TICK, 32'd100);     // all due, scan start kept
    send_cmd(ptrs_pkg::OP_TICK, 32'd101);     // first service only
    send_cmd(ptrs_pkg::OP_TICK, 32'd102);     // scan resumes at the stored index
    send_cmd(ptrs_pkg::OP_TICK, 32'd1000);    // catch-up over many periods
    send_cmd(ptrs_pkg::OP_TICK, 32'd5);       // time behind every release

    // Full set, periods from one to the largest
    per[0] = 16'd1;
    per[1] = 16'd3;
    per[2] = 16'd7;
    per[3] = 16'd100;
    per[4] = 16'd1000;
    per[5] = 16'd30000;
    per[6] = 16'hFFFF;
    load_services(3'd7, per);
    send_cmd(ptrs_pkg::OP_START, 32'd0);
    send_cmd(ptrs_pkg::OP_TICK, 32'd0);
    send_cmd(ptrs_pkg::OP_TICK, 32'd50);
    send_cmd(ptrs_pkg::OP_TICK, 32'd5000);
    send_cmd(ptrs_pkg::OP_TICK, 32'd40000);   // scan start ends at the last service

    // Fewer services than the stored scan start
    load_services(3'd4, per);
    send_cmd(ptrs_pkg::OP_TICK, 32'd40001);

    // Release times pushed past the top of time saturate
    load_services(3'd7, per);
    send_cmd(ptrs_pkg::OP_START, 32'hFFFF_FF00);
    send_cmd(ptrs_pkg::OP_TICK, 32'hFFFF_FFFF);
    send_cmd(ptrs_pkg::OP_TICK, 32'hFFFF_FFFF);
    send_cmd(ptrs_pkg::OP_TICK, 32'hFFFF_FFF0);

    load_services(3'd0, per);
    send_cmd(ptrs_pkg::OP_TICK, 32'd12345);

    // Random settings and sequences; the first one holds off midway
    first = 1'b1;
    while (ticks_sent + starts_sent < ITEM_TARGET) begin
      random_phase($urandom_range(30, 120), first || ($urandom_range(0, 3) == 0));
      first = 1'b0;
    end

    quiet = 1'b0;
    drain();
    repeat (300) @(negedge clk);

    $display("Covered %0d ticks and %0d start commands over %0d register settings.",
             ticks_sent, starts_sent, settings_made);
    $display("%0d service releases were predicted and checked.", released);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS periodic_task_release_scheduler");
    end else begin
      $display("FAIL periodic_task_release_scheduler");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/ptrs_pkg.sv
src/ptrs_regs.sv
src/ptrs_mem.sv
src/ptrs_rem.sv
src/ptrs_seq.sv
src/periodic_task_release_scheduler.sv
tb/release_checker.sv
tb/tb.sv
